// ----- rtl/tss_pkg.sv -----
// Shared types and constants of the seven-segment temperature scanner.
// Used by the converter front end, the frame queue and the scan back end.
package tss_pkg;

   typedef logic [7:0] seg_type;

   // One converted sample, ready to be scanned out
   typedef struct packed {
      seg_type hundreds_seg;
      seg_type tens_seg;
      seg_type ones_seg;
      seg_type glyph_seg;
      logic    below_zero;
   } frame_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   localparam seg_type GLYPH_C = 8'h39;
   localparam seg_type GLYPH_F = 8'h71;
   localparam seg_type DP_MASK = 8'h80;

   localparam logic [1:0] POS_HUNDREDS = 2'd0;
   localparam logic [1:0] POS_TENS     = 2'd1;
   localparam logic [1:0] POS_ONES     = 2'd2;
   localparam logic [1:0] POS_GLYPH    = 2'd3;

   localparam logic [4:0] ROUNDS_RESET = 5'd6;
   localparam logic [4:0] ROUNDS_MAX   = 5'd16;

   function automatic seg_type seg_of_digit(input logic [3:0] digit);
      seg_type seg;
      unique case (digit)
         4'd0: seg = 8'h3F;
         4'd1: seg = 8'h06;
         4'd2: seg = 8'h5B;
         4'd3: seg = 8'h4F;
         4'd4: seg = 8'h66;
         4'd5: seg = 8'h6D;
         4'd6: seg = 8'h7D;
         4'd7: seg = 8'h07;
         4'd8: seg = 8'h7F;
         4'd9: seg = 8'h67;
         default: seg = 8'h00;
      endcase
      return seg;
   endfunction

endpackage

// ----- rtl/tss_front.sv -----
// Converter front end: sample to tenths of a degree, digits and segment codes.
// Eight-stage pipeline feeding the frame queue; depends on tss_pkg.
module tss_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [9:0]                   req_sample,
   input  logic                         req_show_celsius,
   input  tss_pkg::queue_status_type    q_status,
   output logic                         push,
   output tss_pkg::frame_type           push_frame
);
   import tss_pkg::*;

   localparam int NumStages = 8;

   localparam logic [19:0] C_OFFSET = 20'd64000;
   localparam logic [15:0] F_OFFSET = 16'd1600;

   logic                 advance;
   logic                 accept;
   logic [NumStages-1:0] valid_ff, valid_in;

   // stage 0: captured request
   logic [9:0]  s0_sample_ff;
   logic        s0_celsius_ff;
   // stage 1: Celsius in sign-magnitude
   logic [19:0] s1_prod;
   logic [19:0] s1_diff;
   logic        s1_tc_neg_in, s1_tc_neg_ff;
   logic [12:0] s1_tc_mag_in, s1_tc_mag_ff;
   logic        s1_celsius_ff;
   // stage 2: Fahrenheit numerator
   logic [15:0] s2_t9;
   logic        s2_f_neg_in, s2_f_neg_ff;
   logic [15:0] s2_f_mag_in, s2_f_mag_ff;
   logic        s2_tc_neg_ff;
   logic [12:0] s2_tc_mag_ff;
   logic        s2_celsius_ff;
   // stage 3: divide by five
   logic [31:0] s3_prod;
   logic [13:0] s3_q5_in, s3_q5_ff;
   logic        s3_f_neg_ff;
   logic        s3_tc_neg_ff;
   logic [12:0] s3_tc_mag_ff;
   logic        s3_celsius_ff;
   // stage 4: clamp and first divide by ten
   logic [13:0] s4_v_in, s4_v_ff;
   logic        s4_neg_in, s4_neg_ff;
   logic [29:0] s4_prod;
   logic [9:0]  s4_q10_in, s4_q10_ff;
   logic        s4_celsius_ff;
   // stage 5
   logic [13:0] s5_q10x10;
   logic [13:0] s5_ones_diff;
   logic [3:0]  s5_ones_in, s5_ones_ff;
   logic [25:0] s5_prod;
   logic [6:0]  s5_q100_in, s5_q100_ff;
   logic [9:0]  s5_q10_ff;
   logic        s5_neg_ff;
   logic        s5_celsius_ff;
   // stage 6
   logic [9:0]  s6_q100x10;
   logic [9:0]  s6_tens_diff;
   logic [3:0]  s6_tens_in, s6_tens_ff;
   logic [14:0] s6_prod;
   logic [3:0]  s6_q1000_in, s6_q1000_ff;
   logic [6:0]  s6_q100_ff;
   logic [3:0]  s6_ones_ff;
   logic        s6_neg_ff;
   logic        s6_celsius_ff;
   // stage 7: segment codes
   logic [6:0]  s7_q1000x10;
   logic [6:0]  s7_hund_diff;
   frame_type   s7_frame_in, s7_frame_ff;

   assign advance = !(valid_ff[NumStages-1] && q_status.full);
   assign busy    = !advance;
   assign accept  = start && !busy;
   assign push       = valid_ff[NumStages-1] && !q_status.full;
   assign push_frame = s7_frame_ff;

   always_comb begin
      valid_in = valid_ff;
      if (advance) begin
         valid_in = {valid_ff[NumStages-2:0], accept};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      // Celsius tenths, truncated toward zero
      s1_prod = {10'd0, s0_sample_ff} * 20'd625;
      if (s1_prod >= C_OFFSET) begin
         s1_diff      = s1_prod - C_OFFSET;
         s1_tc_neg_in = 1'b0;
      end else begin
         s1_diff      = C_OFFSET - s1_prod;
         s1_tc_neg_in = 1'b1;
      end
      s1_tc_mag_in = s1_diff[19:7];

      // Fahrenheit numerator from the unclamped Celsius value
      s2_t9 = {3'd0, s1_tc_mag_ff} * 16'd9;
      if (!s1_tc_neg_ff) begin
         s2_f_neg_in = 1'b0;
         s2_f_mag_in = s2_t9 + F_OFFSET;
      end else if (s2_t9 > F_OFFSET) begin
         s2_f_neg_in = 1'b1;
         s2_f_mag_in = s2_t9 - F_OFFSET;
      end else begin
         s2_f_neg_in = 1'b0;
         s2_f_mag_in = F_OFFSET - s2_t9;
      end

      s3_prod  = {16'd0, s2_f_mag_ff} * 32'd52429;
      s3_q5_in = s3_prod[31:18];

      // A magnitude that truncates to zero is not below zero
      if (s3_celsius_ff) begin
         s4_neg_in = s3_tc_neg_ff && (s3_tc_mag_ff != 13'd0);
         s4_v_in   = s3_tc_neg_ff ? 14'd0 : {1'b0, s3_tc_mag_ff};
      end else begin
         s4_neg_in = s3_f_neg_ff && (s3_q5_ff != 14'd0);
         s4_v_in   = s3_f_neg_ff ? 14'd0 : s3_q5_ff;
      end
      s4_prod   = {16'd0, s4_v_in} * 30'd52429;
      s4_q10_in = s4_prod[28:19];

      s5_q10x10    = {4'd0, s4_q10_ff} * 14'd10;
      s5_ones_diff = s4_v_ff - s5_q10x10;
      s5_ones_in   = s5_ones_diff[3:0];
      s5_prod      = {16'd0, s4_q10_ff} * 26'd52429;
      s5_q100_in   = s5_prod[25:19];

      s6_q100x10   = {3'd0, s5_q100_ff} * 10'd10;
      s6_tens_diff = s5_q10_ff - s6_q100x10;
      s6_tens_in   = s6_tens_diff[3:0];
      s6_prod      = {8'd0, s5_q100_ff} * 15'd205;
      s6_q1000_in  = s6_prod[14:11];

      s7_q1000x10  = {3'd0, s6_q1000_ff} * 7'd10;
      s7_hund_diff = s6_q100_ff - s7_q1000x10;
      s7_frame_in.hundreds_seg = seg_of_digit(s7_hund_diff[3:0]);
      s7_frame_in.tens_seg     = seg_of_digit(s6_tens_ff) | DP_MASK;
      s7_frame_in.ones_seg     = seg_of_digit(s6_ones_ff);
      s7_frame_in.glyph_seg    = s6_celsius_ff ? GLYPH_C : GLYPH_F;
      s7_frame_in.below_zero   = s6_neg_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_sample_ff  <= req_sample;
         s0_celsius_ff <= req_show_celsius;

         s1_tc_neg_ff  <= s1_tc_neg_in;
         s1_tc_mag_ff  <= s1_tc_mag_in;
         s1_celsius_ff <= s0_celsius_ff;

         s2_f_neg_ff   <= s2_f_neg_in;
         s2_f_mag_ff   <= s2_f_mag_in;
         s2_tc_neg_ff  <= s1_tc_neg_ff;
         s2_tc_mag_ff  <= s1_tc_mag_ff;
         s2_celsius_ff <= s1_celsius_ff;

         s3_q5_ff      <= s3_q5_in;
         s3_f_neg_ff   <= s2_f_neg_ff;
         s3_tc_neg_ff  <= s2_tc_neg_ff;
         s3_tc_mag_ff  <= s2_tc_mag_ff;
         s3_celsius_ff <= s2_celsius_ff;

         s4_v_ff       <= s4_v_in;
         s4_neg_ff     <= s4_neg_in;
         s4_q10_ff     <= s4_q10_in;
         s4_celsius_ff <= s3_celsius_ff;

         s5_ones_ff    <= s5_ones_in;
         s5_q100_ff    <= s5_q100_in;
         s5_q10_ff     <= s4_q10_ff;
         s5_neg_ff     <= s4_neg_ff;
         s5_celsius_ff <= s4_celsius_ff;

         s6_tens_ff    <= s6_tens_in;
         s6_q1000_ff   <= s6_q1000_in;
         s6_q100_ff    <= s5_q100_ff;
         s6_ones_ff    <= s5_ones_ff;
         s6_neg_ff     <= s5_neg_ff;
         s6_celsius_ff <= s5_celsius_ff;

         s7_frame_ff   <= s7_frame_in;
      end
   end

endmodule

// ----- rtl/tss_queue.sv -----
// Small frame queue between the converter and the scanner.
// Register-based FIFO of tss_pkg::frame_type entries; depends on tss_pkg.
module tss_queue #(
   parameter int DEPTH = 2
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  tss_pkg::frame_type           push_frame,
   input  logic                         pop,
   output tss_pkg::frame_type           head_frame,
   output tss_pkg::queue_status_type    q_status
);
   import tss_pkg::*;

   localparam int PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntWidth = $clog2(DEPTH + 1);
   localparam logic [PtrWidth-1:0] PtrLast = PtrWidth'(DEPTH - 1);
   localparam logic [CntWidth-1:0] CntFull = CntWidth'(DEPTH);

   frame_type             mem_ff [DEPTH];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]   count_ff, count_in;
   logic                  do_push, do_pop;

   assign q_status.full  = (count_ff == CntFull);
   assign q_status.empty = (count_ff == '0);
   assign head_frame     = mem_ff[rd_ptr_ff];

   assign do_push = push && !q_status.full;
   assign do_pop  = pop && !q_status.empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_frame;
      end
   end

endmodule

// ----- rtl/tss_back.sv -----
// Scan back end: emits one display frame per cycle for the configured rounds.
// Pulls converted samples from tss_queue; depends on tss_pkg.
module tss_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [4:0]                   scan_rounds,
   input  tss_pkg::frame_type           head_frame,
   input  tss_pkg::queue_status_type    q_status,
   output logic                         pop,
   output logic                         rsp_strobe,
   output logic [7:0]                   rsp_segments,
   output logic [1:0]                   rsp_digit_position,
   output logic                         rsp_below_zero,
   output logic                         rsp_last
);
   import tss_pkg::*;

   logic        active_ff, active_in;
   frame_type   frame_ff, frame_in;
   logic [1:0]  pos_ff, pos_in;
   logic [3:0]  round_ff, round_in;
   logic [4:0]  round_limit;
   logic        finishing;

   // Zero rounds means one, and the count saturates at the maximum
   always_comb begin
      if (scan_rounds == 5'd0) begin
         round_limit = 5'd1;
      end else if (scan_rounds > ROUNDS_MAX) begin
         round_limit = ROUNDS_MAX;
      end else begin
         round_limit = scan_rounds;
      end
   end

   assign finishing = active_ff && (pos_ff == POS_GLYPH)
                      && ({1'b0, round_ff} == round_limit - 5'd1);
   // Load the next sample in the cycle the current run ends: no gap
   assign pop = (!active_ff || finishing) && !q_status.empty;

   always_comb begin
      active_in = active_ff;
      frame_in  = frame_ff;
      pos_in    = pos_ff;
      round_in  = round_ff;
      if (pop) begin
         active_in = 1'b1;
         frame_in  = head_frame;
         pos_in    = POS_HUNDREDS;
         round_in  = '0;
      end else if (finishing) begin
         active_in = 1'b0;
      end else if (active_ff) begin
         pos_in = pos_ff + 2'd1;
         if (pos_ff == POS_GLYPH) begin
            round_in = round_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         pos_ff    <= POS_HUNDREDS;
         round_ff  <= '0;
      end else begin
         active_ff <= active_in;
         pos_ff    <= pos_in;
         round_ff  <= round_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
   end

   always_comb begin
      unique case (pos_ff)
         POS_HUNDREDS: rsp_segments = frame_ff.hundreds_seg;
         POS_TENS:     rsp_segments = frame_ff.tens_seg;
         POS_ONES:     rsp_segments = frame_ff.ones_seg;
         POS_GLYPH:    rsp_segments = frame_ff.glyph_seg;
         default:      rsp_segments = frame_ff.glyph_seg;
      endcase
   end

   assign rsp_strobe         = active_ff;
   assign rsp_digit_position = pos_ff;
   assign rsp_below_zero     = frame_ff.below_zero;
   assign rsp_last           = finishing;

`ifndef SYNTH
   a_last_on_glyph: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last |-> rsp_digit_position == POS_GLYPH)
      else $error("last frame not on glyph position");

   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |=> rsp_strobe
         && rsp_digit_position == 2'($past(rsp_digit_position) + 2'd1))
      else $error("scan run broke before its last frame");

   a_dp_on_tens: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_digit_position == POS_TENS |-> rsp_segments[7])
      else $error("decimal point missing on tens position");

   a_round_bound: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> {1'b0, round_ff} < round_limit)
      else $error("round counter beyond limit");
`endif

endmodule

// ----- rtl/temperature_seven_segment_scan_top.sv -----
// Top level of the seven-segment temperature scanner.
// Instantiates tss_front, tss_queue and tss_back; depends on tss_pkg.
//
// A request (start high while busy is low) carries a 10-bit sensor sample and a
// unit select. The converter pipeline turns it into three digits and a unit
// glyph and parks the result in a small queue; the scanner then drives one
// frame per cycle on rsp_* with rsp_strobe high, four frames per round (tens,
// ones with decimal point, tenths, glyph), for csr rounds clamped to 1..16
// (6 at reset). Runs follow each other without a gap while the queue holds a
// sample. rsp_last marks the final frame of a run. Frames cannot be held off:
// capture them in the cycle shown. busy rises only when the queue is full and
// a converted sample waits to enter it. Write csr_wr_data with csr_wr_en only
// while no sample is in flight.
module temperature_seven_segment_scan_top #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [9:0]  req_sample,
   input  logic        req_show_celsius,
   input  logic        csr_wr_en,
   input  logic [4:0]  csr_wr_data,
   output logic        rsp_strobe,
   output logic [7:0]  rsp_segments,
   output logic [1:0]  rsp_digit_position,
   output logic        rsp_below_zero,
   output logic        rsp_last
);
   import tss_pkg::*;

   logic [4:0]        scan_rounds_ff, scan_rounds_in;
   queue_status_type  q_status;
   logic              push;
   frame_type         push_frame;
   logic              pop;
   frame_type         head_frame;

   assign scan_rounds_in = csr_wr_en ? csr_wr_data : scan_rounds_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_rounds_ff <= ROUNDS_RESET;
      end else begin
         scan_rounds_ff <= scan_rounds_in;
      end
   end

   tss_front u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_sample       (req_sample),
      .req_show_celsius (req_show_celsius),
      .q_status         (q_status),
      .push             (push),
      .push_frame       (push_frame)
   );

   tss_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_frame (push_frame),
      .pop        (pop),
      .head_frame (head_frame),
      .q_status   (q_status)
   );

   tss_back u_back (
      .clock              (clock),
      .reset              (reset),
      .scan_rounds        (scan_rounds_ff),
      .head_frame         (head_frame),
      .q_status           (q_status),
      .pop                (pop),
      .rsp_strobe         (rsp_strobe),
      .rsp_segments       (rsp_segments),
      .rsp_digit_position (rsp_digit_position),
      .rsp_below_zero     (rsp_below_zero),
      .rsp_last           (rsp_last)
   );

endmodule
